// ===== src/manifest_text_tokenizer_unit_macros.svh =====
// Assertion helpers shared by the tokenizer RTL.
// Every assertion runs on clk_i and is disabled while rst_ni is low.
`ifndef MANIFEST_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define MANIFEST_TEXT_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define MTT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Types, character codes and character classes for the manifest tokenizer.
// ----------------------------------------------------------------------------
package mtt_pkg;

  // Scanner mode; code 7 is unused and scans as between tokens
  typedef enum logic [2:0] {
    SCAN_IDLE    = 3'd0,
    SCAN_IDENT   = 3'd1,
    SCAN_NUMBER  = 3'd2,
    SCAN_STRING  = 3'd3,
    SCAN_ESCAPE  = 3'd4,
    SCAN_COMMENT = 3'd5,
    SCAN_ENDED   = 3'd6
  } scan_mode_e;

  typedef enum logic [3:0] {
    TK_END      = 4'd0,
    TK_IDENT    = 4'd1,
    TK_STRING   = 4'd2,
    TK_NUMBER   = 4'd3,
    TK_LBRACE   = 4'd4,
    TK_RBRACE   = 4'd5,
    TK_LBRACKET = 4'd6,
    TK_RBRACKET = 4'd7,
    TK_COLON    = 4'd8,
    TK_COMMA    = 4'd9,
    TK_NEWLINE  = 4'd10,
    TK_COMMENT  = 4'd11,
    TK_INVALID  = 4'd12
  } token_kind_e;

  // Which token slots one scanned beat fills
  typedef struct packed {
    logic tok0_valid;
    logic tok1_valid;
  } scan_ctl_t;

  localparam int KIND_BITS  = 4;
  localparam int FIFO_DEPTH = 8;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_VTAB       = 8'h0B;
  localparam logic [7:0] CH_FORMFEED   = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE) || (c == CH_MINUS) ||
           (c == CH_DOT) || (c == CH_SLASH) || (c == CH_AT);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
           (c == CH_VTAB) || (c == CH_FORMFEED);
  endfunction

endpackage

// ===== src/mtt_scan.sv =====
// ----------------------------------------------------------------------------
// mtt_scan
// Combinational scanner: one byte against the current mode and position
// gives up to two tokens and the next mode, position and open token.
// ----------------------------------------------------------------------------
module mtt_scan import mtt_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int OFFSET_BITS   = 20,
  parameter int LENGTH_BITS   = 12
) (
  input  scan_mode_e               mode_i,
  input  logic [7:0]               text_byte_i,
  input  logic                     end_of_text_i,
  input  logic [POSITION_BITS-1:0] line_i,
  input  logic [POSITION_BITS-1:0] column_i,
  input  logic [OFFSET_BITS-1:0]   offset_i,
  input  logic [POSITION_BITS-1:0] open_line_i,
  input  logic [POSITION_BITS-1:0] open_column_i,
  input  logic [OFFSET_BITS-1:0]   open_start_i,
  input  logic [LENGTH_BITS-1:0]   open_length_i,
  output scan_mode_e               mode_o,
  output logic [POSITION_BITS-1:0] line_o,
  output logic [POSITION_BITS-1:0] column_o,
  output logic [OFFSET_BITS-1:0]   offset_o,
  output logic [POSITION_BITS-1:0] open_line_o,
  output logic [POSITION_BITS-1:0] open_column_o,
  output logic [OFFSET_BITS-1:0]   open_start_o,
  output logic [LENGTH_BITS-1:0]   open_length_o,
  output scan_ctl_t                ctl_o,
  output token_kind_e              tok0_kind_o,
  output logic [POSITION_BITS-1:0] tok0_line_o,
  output logic [POSITION_BITS-1:0] tok0_column_o,
  output logic [OFFSET_BITS-1:0]   tok0_start_o,
  output logic [LENGTH_BITS-1:0]   tok0_length_o,
  output token_kind_e              tok1_kind_o,
  output logic [POSITION_BITS-1:0] tok1_line_o,
  output logic [POSITION_BITS-1:0] tok1_column_o,
  output logic [OFFSET_BITS-1:0]   tok1_start_o,
  output logic [LENGTH_BITS-1:0]   tok1_length_o
);

  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0]   OfsMax = {OFFSET_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0]   LenMax = {LENGTH_BITS{1'b1}};

  logic                     ending;
  logic                     is_nl;
  logic [OFFSET_BITS-1:0]   ofs_inc;
  logic [LENGTH_BITS-1:0]   len_inc;
  logic [POSITION_BITS-1:0] adv_line;
  logic [POSITION_BITS-1:0] adv_column;

  logic                     idle_single;
  logic                     idle_open;
  token_kind_e              idle_kind;
  scan_mode_e               idle_mode;
  logic [OFFSET_BITS-1:0]   idle_start;
  logic [LENGTH_BITS-1:0]   idle_length;

  logic                     open_live;
  token_kind_e              open_kind;

  // Classify the byte and compute the advanced position
  always_comb begin
    ending     = end_of_text_i || (text_byte_i == CH_NUL);
    is_nl      = (text_byte_i == CH_NEWLINE);
    ofs_inc    = (offset_i == OfsMax) ? offset_i : offset_i + OFFSET_BITS'(1);
    len_inc    = (open_length_i == LenMax) ? open_length_i
                                           : open_length_i + LENGTH_BITS'(1);
    adv_line   = line_i;
    adv_column = POSITION_BITS'(1);
    if (is_nl) begin
      adv_line = (line_i == PosMax) ? line_i : line_i + POSITION_BITS'(1);
    end else begin
      adv_column = (column_i == PosMax) ? column_i : column_i + POSITION_BITS'(1);
    end
  end

  // Scan the byte as if between tokens
  always_comb begin
    idle_single = 1'b1;
    idle_open   = 1'b0;
    idle_kind   = TK_INVALID;
    idle_mode   = SCAN_IDLE;
    idle_start  = offset_i;
    idle_length = LENGTH_BITS'(1);
    if (is_blank(text_byte_i)) begin
      idle_single = 1'b0;
    end else if (text_byte_i == CH_HASH) begin
      idle_single = 1'b0;
      idle_open   = 1'b1;
      idle_mode   = SCAN_COMMENT;
    end else if (text_byte_i == CH_QUOTE) begin
      idle_single = 1'b0;
      idle_open   = 1'b1;
      idle_mode   = SCAN_STRING;
      idle_start  = ofs_inc;
      idle_length = '0;
    end else if (is_alpha(text_byte_i) || (text_byte_i == CH_UNDERSCORE)) begin
      idle_single = 1'b0;
      idle_open   = 1'b1;
      idle_mode   = SCAN_IDENT;
    end else if (is_digit(text_byte_i)) begin
      idle_single = 1'b0;
      idle_open   = 1'b1;
      idle_mode   = SCAN_NUMBER;
    end else if (is_nl) begin
      idle_kind = TK_NEWLINE;
    end else if (text_byte_i == CH_LBRACE) begin
      idle_kind = TK_LBRACE;
    end else if (text_byte_i == CH_RBRACE) begin
      idle_kind = TK_RBRACE;
    end else if (text_byte_i == CH_LBRACKET) begin
      idle_kind = TK_LBRACKET;
    end else if (text_byte_i == CH_RBRACKET) begin
      idle_kind = TK_RBRACKET;
    end else if (text_byte_i == CH_COLON) begin
      idle_kind = TK_COLON;
    end else if (text_byte_i == CH_COMMA) begin
      idle_kind = TK_COMMA;
    end
  end

  // Kind of the token held open by the current mode
  always_comb begin
    open_live = 1'b1;
    case (mode_i)
      SCAN_IDENT:   open_kind = TK_IDENT;
      SCAN_NUMBER:  open_kind = TK_NUMBER;
      SCAN_STRING:  open_kind = TK_STRING;
      SCAN_ESCAPE:  open_kind = TK_STRING;
      SCAN_COMMENT: open_kind = TK_COMMENT;
      default: begin
        open_kind = TK_END;
        open_live = 1'b0;
      end
    endcase
  end

  // Next state and emitted tokens
  always_comb begin
    mode_o        = mode_i;
    line_o        = line_i;
    column_o      = column_i;
    offset_o      = offset_i;
    open_line_o   = open_line_i;
    open_column_o = open_column_i;
    open_start_o  = open_start_i;
    open_length_o = open_length_i;
    ctl_o         = '0;
    tok0_kind_o   = open_kind;
    tok0_line_o   = open_line_i;
    tok0_column_o = open_column_i;
    tok0_start_o  = open_start_i;
    tok0_length_o = open_length_i;
    tok1_kind_o   = idle_kind;
    tok1_line_o   = line_i;
    tok1_column_o = column_i;
    tok1_start_o  = offset_i;
    tok1_length_o = '0;

    if (mode_i == SCAN_ENDED) begin
      // Repeat the end token, hold everything
      ctl_o.tok0_valid = 1'b1;
      tok0_kind_o      = TK_END;
      tok0_line_o      = line_i;
      tok0_column_o    = column_i;
      tok0_start_o     = offset_i;
      tok0_length_o    = '0;
    end else if (ending) begin
      // Close any open token, then emit end
      ctl_o.tok0_valid = 1'b1;
      mode_o           = SCAN_ENDED;
      if (open_live) begin
        ctl_o.tok1_valid = 1'b1;
        tok1_kind_o      = TK_END;
      end else begin
        tok0_kind_o   = TK_END;
        tok0_line_o   = line_i;
        tok0_column_o = column_i;
        tok0_start_o  = offset_i;
        tok0_length_o = '0;
      end
    end else begin
      line_o   = adv_line;
      column_o = adv_column;
      offset_o = ofs_inc;
      case (mode_i)
        SCAN_IDENT, SCAN_NUMBER, SCAN_COMMENT: begin
          if ((mode_i == SCAN_COMMENT) ? !is_nl : is_word_char(text_byte_i)) begin
            open_length_o = len_inc;
          end else begin
            // Close the open token and rescan the byte between tokens
            ctl_o.tok0_valid = 1'b1;
            ctl_o.tok1_valid = idle_single;
            mode_o           = idle_mode;
            if (idle_open) begin
              open_line_o   = line_i;
              open_column_o = column_i;
              open_start_o  = idle_start;
              open_length_o = idle_length;
            end
          end
        end
        SCAN_STRING: begin
          if (text_byte_i == CH_QUOTE) begin
            ctl_o.tok0_valid = 1'b1;
            mode_o           = SCAN_IDLE;
          end else begin
            open_length_o = len_inc;
            if (text_byte_i == CH_BACKSLASH) begin
              mode_o = SCAN_ESCAPE;
            end
          end
        end
        SCAN_ESCAPE: begin
          open_length_o = len_inc;
          mode_o        = SCAN_STRING;
        end
        default: begin
          // Between tokens
          ctl_o.tok0_valid = idle_single;
          tok0_kind_o      = idle_kind;
          tok0_line_o      = line_i;
          tok0_column_o    = column_i;
          tok0_start_o     = offset_i;
          tok0_length_o    = '0;
          mode_o           = idle_mode;
          if (idle_open) begin
            open_line_o   = line_i;
            open_column_o = column_i;
            open_start_o  = idle_start;
            open_length_o = idle_length;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/mtt_token_fifo.sv =====
// ----------------------------------------------------------------------------
// mtt_token_fifo
// Result queue: takes up to two tokens a cycle, hands out one per beat.
// ----------------------------------------------------------------------------
`include "manifest_text_tokenizer_unit_macros.svh"

module mtt_token_fifo import mtt_pkg::*; #(
  parameter int WIDTH = 69,
  parameter int DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push0_i,
  input  logic                       push1_i,
  input  logic [WIDTH-1:0]           data0_i,
  input  logic [WIDTH-1:0]           data1_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr_nxt, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic [1:0]       push_n;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LastIdx) ? '0 : p + AW'(1);
  endfunction

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_nxt = ptr_inc(wr_ptr_q);
    push_n     = {1'b0, push0_i} + {1'b0, push1_i};
    wr_ptr_d   = wr_ptr_q;
    if (push1_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_nxt);
    end else if (push0_i) begin
      wr_ptr_d = wr_ptr_nxt;
    end
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push_n) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the entries
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nxt] <= data1_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = count_q;

  `MTT_ASSERT_IMP(a_fifo_level_bound, 1'b1, count_q <= CW'(DEPTH), "token queue level out of range")
  `MTT_ASSERT_IMP(a_fifo_no_overflow, push0_i, ({1'b0, count_q} + (CW+1)'(push_n)) <= (CW+1)'(DEPTH), "token queue overflow")
  `MTT_ASSERT_IMP(a_fifo_push_order, push1_i, push0_i, "second token pushed without first")

endmodule

// ===== src/manifest_text_tokenizer_unit.sv =====
// A byte beat passes the input byte register and the token queue before its first token shows at out_valid_o.
// Throughput: one byte per cycle; a byte that yields two tokens gives two output tokens,
//   and the eight-entry token queue absorbs these until it nears full and in_stall_o rises.
// Reset: rst_ni asynchronous, active low; clears the scanner to between tokens at
//   line 1, column 1, offset 0 and empties the token queue.
// ----------------------------------------------------------------------------
// manifest_text_tokenizer_unit
// Streaming tokenizer for manifest text: input byte register, scanner,
// position state and a result token queue.
// ----------------------------------------------------------------------------
`include "manifest_text_tokenizer_unit_macros.svh"

module manifest_text_tokenizer_unit import mtt_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int OFFSET_BITS   = 20,
  parameter int LENGTH_BITS   = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               text_byte_i,
  input  logic                     end_of_text_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [KIND_BITS-1:0]     token_kind_o,
  output logic [POSITION_BITS-1:0] token_line_o,
  output logic [POSITION_BITS-1:0] token_column_o,
  output logic [OFFSET_BITS-1:0]   value_start_o,
  output logic [LENGTH_BITS-1:0]   value_length_o,
  output logic                     last_of_run_o
);

  localparam int TW = KIND_BITS + 2 * POSITION_BITS + OFFSET_BITS + LENGTH_BITS + 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int LenLo  = 1;
  localparam int OfsLo  = LenLo + LENGTH_BITS;
  localparam int ColLo  = OfsLo + OFFSET_BITS;
  localparam int LineLo = ColLo + POSITION_BITS;
  localparam int KindLo = LineLo + POSITION_BITS;

  // Input byte register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eot_q;
  logic       in_fire;

  // Scanner state
  scan_mode_e               mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d, column_q, column_d;
  logic [OFFSET_BITS-1:0]   offset_q, offset_d;
  logic [POSITION_BITS-1:0] open_line_q, open_line_d, open_column_q, open_column_d;
  logic [OFFSET_BITS-1:0]   open_start_q, open_start_d;
  logic [LENGTH_BITS-1:0]   open_length_q, open_length_d;

  // Scanner results
  scan_ctl_t                ctl;
  token_kind_e              tok0_kind, tok1_kind;
  logic [POSITION_BITS-1:0] tok0_line, tok0_column, tok1_line, tok1_column;
  logic [OFFSET_BITS-1:0]   tok0_start, tok1_start;
  logic [LENGTH_BITS-1:0]   tok0_length, tok1_length;
  logic [TW-1:0]            tok0_word, tok1_word, head_word;
  logic [CW-1:0]            level;
  logic                     pop;

  // Accept a beat only when the queue has room for two more tokens
  // beyond what the registered byte may still push
  assign in_stall_o = ({1'b0, level} + (s1_valid_q ? (CW+1)'(2) : '0)) >
                      (CW+1)'(FIFO_DEPTH - 2);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_byte_i;
      s1_eot_q  <= end_of_text_i;
    end
  end

  mtt_scan #(
    .POSITION_BITS(POSITION_BITS),
    .OFFSET_BITS  (OFFSET_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_scan (
    .mode_i       (mode_q),
    .text_byte_i  (s1_byte_q),
    .end_of_text_i(s1_eot_q),
    .line_i       (line_q),
    .column_i     (column_q),
    .offset_i     (offset_q),
    .open_line_i  (open_line_q),
    .open_column_i(open_column_q),
    .open_start_i (open_start_q),
    .open_length_i(open_length_q),
    .mode_o       (mode_d),
    .line_o       (line_d),
    .column_o     (column_d),
    .offset_o     (offset_d),
    .open_line_o  (open_line_d),
    .open_column_o(open_column_d),
    .open_start_o (open_start_d),
    .open_length_o(open_length_d),
    .ctl_o        (ctl),
    .tok0_kind_o  (tok0_kind),
    .tok0_line_o  (tok0_line),
    .tok0_column_o(tok0_column),
    .tok0_start_o (tok0_start),
    .tok0_length_o(tok0_length),
    .tok1_kind_o  (tok1_kind),
    .tok1_line_o  (tok1_line),
    .tok1_column_o(tok1_column),
    .tok1_start_o (tok1_start),
    .tok1_length_o(tok1_length)
  );

  // Update scanner state once per registered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= SCAN_IDLE;
      line_q        <= POSITION_BITS'(1);
      column_q      <= POSITION_BITS'(1);
      offset_q      <= '0;
      open_line_q   <= POSITION_BITS'(1);
      open_column_q <= POSITION_BITS'(1);
      open_start_q  <= '0;
      open_length_q <= '0;
    end else if (s1_valid_q) begin
      mode_q        <= mode_d;
      line_q        <= line_d;
      column_q      <= column_d;
      offset_q      <= offset_d;
      open_line_q   <= open_line_d;
      open_column_q <= open_column_d;
      open_start_q  <= open_start_d;
      open_length_q <= open_length_d;
    end
  end

  // Pack tokens; the last one of the beat carries the run flag
  assign tok0_word = {tok0_kind, tok0_line, tok0_column, tok0_start, tok0_length,
                      !ctl.tok1_valid};
  assign tok1_word = {tok1_kind, tok1_line, tok1_column, tok1_start, tok1_length, 1'b1};

  assign pop = out_valid_o && !out_stall_i;

  mtt_token_fifo #(
    .WIDTH(TW),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push0_i(s1_valid_q && ctl.tok0_valid),
    .push1_i(s1_valid_q && ctl.tok1_valid),
    .data0_i(tok0_word),
    .data1_i(tok1_word),
    .pop_i  (pop),
    .valid_o(out_valid_o),
    .data_o (head_word),
    .level_o(level)
  );

  // Unpack the head token
  assign token_kind_o   = head_word[KindLo +: KIND_BITS];
  assign token_line_o   = head_word[LineLo +: POSITION_BITS];
  assign token_column_o = head_word[ColLo +: POSITION_BITS];
  assign value_start_o  = head_word[OfsLo +: OFFSET_BITS];
  assign value_length_o = head_word[LenLo +: LENGTH_BITS];
  assign last_of_run_o  = head_word[0];

  `MTT_ASSERT_NXT(a_ended_sticky, mode_q == SCAN_ENDED, mode_q == SCAN_ENDED, "scanner left ended mode")
  `MTT_ASSERT_IMP(a_ended_single_end, s1_valid_q && mode_q == SCAN_ENDED, ctl.tok0_valid && !ctl.tok1_valid && tok0_kind == TK_END, "ended scanner must emit one end token")
  `MTT_ASSERT_IMP(a_second_after_first, s1_valid_q && ctl.tok1_valid, ctl.tok0_valid, "second token without first")
  `MTT_ASSERT_NXT(a_end_enters_ended, s1_valid_q && (s1_eot_q || s1_byte_q == CH_NUL), mode_q == SCAN_ENDED, "end of text did not end the scan")

endmodule
